FILE: sv/prd_pkg.sv
// Shared types and constants of the pinhole ray direction pipeline.
// Used by the top level, the square root unit and the divider; no dependencies.
package prd_pkg;

  // Field and datapath widths
  localparam int unsigned NumComp = 3;   // x, y, z
  localparam int unsigned CoordW  = 17;  // unsigned Q1.16 screen coordinate
  localparam int unsigned CompW   = 21;  // signed Q10.10 vector component
  localparam int unsigned RegW    = 63;  // three packed components
  localparam int unsigned DataW   = 64;  // APB data
  localparam int unsigned AddrW   = 5;   // registers at 8*i
  localparam int unsigned ProdW   = 39;  // coordinate times component
  localparam int unsigned SumW    = 41;  // unnormalized direction component
  localparam int unsigned MagW    = 40;  // magnitude of a component
  localparam int unsigned PosW    = 6;   // bit position within MagW
  localparam int unsigned NormW   = 30;  // normalized magnitude, top bit at NormMsb
  localparam int unsigned NormMsb = 29;
  localparam int unsigned SqW     = 60;  // square of a normalized magnitude
  localparam int unsigned RadW    = 62;  // sum of three squares
  localparam int unsigned RootW   = 31;  // integer square root of RadW bits
  localparam int unsigned RemW    = 32;  // partial remainder with one bit brought down
  localparam int unsigned QuotW   = 16;  // quotient, at most 1.0 in Q1.15
  localparam int unsigned NumW    = 46;  // rounded dividend
  localparam int unsigned DirW    = 16;  // signed Q1.15 output

  localparam logic [QuotW-1:0] QuotOne = 16'h8000;
  localparam logic [DirW-1:0]  DirMax  = 16'h7FFF;

  // Register map, index = paddr[4:3]
  typedef enum logic [1:0] {
    RegCorner = 2'd0,
    RegHspan  = 2'd1,
    RegVspan  = 2'd2
  } prd_reg_e;

  // Request and result payloads
  typedef struct packed {
    logic [CoordW-1:0] screen_x;
    logic [CoordW-1:0] screen_y;
  } prd_in_t;

  typedef struct packed {
    logic signed [DirW-1:0] dir_x;
    logic signed [DirW-1:0] dir_y;
    logic signed [DirW-1:0] dir_z;
    logic                   degenerate;
  } prd_out_t;

  // Sign and zero-vector flags that ride along with the arithmetic
  typedef struct packed {
    logic [NumComp-1:0] neg;
    logic               degen;
  } prd_flags_t;

  // Normalized magnitudes plus flags, carried past the square root
  typedef struct packed {
    logic [NumComp-1:0][NormW-1:0] e;
    prd_flags_t                    flags;
  } prd_side_t;

  // Pick component k out of a packed register
  function automatic logic signed [CompW-1:0] prd_comp(logic [RegW-1:0] r, int unsigned k);
    return r[k*CompW +: CompW];
  endfunction

endpackage

FILE: sv/prd_isqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on prd_pkg for widths and the sideband struct.
module prd_isqrt import prd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  logic [RadW-1:0] radicand_i,
  input  prd_side_t       side_i,
  output logic            valid_o,
  output logic [RootW-1:0] root_o,
  output prd_side_t       side_o
);

  // Element 0 is the input, element i+1 the register after step i
  logic                 vld_s  [RootW+1];
  logic [RadW-1:0]      rad_s  [RootW+1];
  logic [RemW-1:0]      rem_s  [RootW+1];
  logic [RootW-1:0]     root_s [RootW+1];
  prd_side_t            side_s [RootW+1];

  assign vld_s[0]  = valid_i;
  assign rad_s[0]  = radicand_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = side_i;

  for (genvar i = 0; i < RootW; i++) begin : g_step
    logic [RemW+1:0]  cur;
    logic [RemW+1:0]  trial;
    logic             ge;
    logic [RemW-1:0]  rem_n;
    logic [RootW-1:0] root_n;

    // Bring down the next bit pair and try root*4+1
    always_comb begin
      cur    = {rem_s[i], rad_s[i][2*(RootW-1-i) +: 2]};
      trial  = (RemW+2)'({root_s[i], 2'b01});
      ge     = (cur >= trial);
      rem_n  = ge ? RemW'(cur - trial) : RemW'(cur);
      root_n = {root_s[i][RootW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[i+1] <= 1'b0;
      end else if (adv_i) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rad_s[i+1]  <= rad_s[i];
        rem_s[i+1]  <= rem_n;
        root_s[i+1] <= root_n;
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign valid_o = vld_s[RootW];
  assign root_o  = root_s[RootW];
  assign side_o  = side_s[RootW];

  // A normalized nonzero vector has length of at least 2^29
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !side_o.flags.degen |-> root_o[RootW-1:NormMsb] != '0)
    else $error("square root below normalized range");

endmodule

FILE: sv/prd_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on prd_pkg; forms the rounded dividend e*2^15 + floor(L/2) in its first stage.
module prd_div import prd_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [RootW-1:0]              divisor_i,
  input  prd_side_t                     side_i,
  output logic                          valid_o,
  output logic [NumComp-1:0][QuotW-1:0] q_o,
  output prd_flags_t                    flags_o
);

  logic                              vld_s   [QuotW+1];
  logic [RootW-1:0]                  div_s   [QuotW+1];
  logic [NumComp-1:0][RootW-1:0]     rem_s   [QuotW+1];
  logic [NumComp-1:0][QuotW-1:0]     low_s   [QuotW+1];
  logic [NumComp-1:0][QuotW-1:0]     q_s     [QuotW+1];
  prd_flags_t                        flags_s [QuotW+1];

  logic [NumComp-1:0][NumW-1:0]      num;

  // Form the rounded dividend; its upper part is already below the divisor
  always_comb begin
    for (int k = 0; k < NumComp; k++) begin
      num[k] = (NumW'(side_i.e[k]) << (QuotW-1)) + NumW'(divisor_i >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s[0] <= 1'b0;
    end else if (adv_i) begin
      vld_s[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      div_s[0]   <= divisor_i;
      flags_s[0] <= side_i.flags;
      q_s[0]     <= '0;
      for (int k = 0; k < NumComp; k++) begin
        rem_s[0][k] <= RootW'(num[k][NumW-1:QuotW]);
        low_s[0][k] <= num[k][QuotW-1:0];
      end
    end
  end

  for (genvar j = 0; j < QuotW; j++) begin : g_step
    logic [RemW-1:0]               cur [NumComp];
    logic [NumComp-1:0]            ge;
    logic [NumComp-1:0][RootW-1:0] rem_n;
    logic [NumComp-1:0][QuotW-1:0] q_n;

    // Shift in the next dividend bit and subtract where it fits
    always_comb begin
      for (int k = 0; k < NumComp; k++) begin
        cur[k]   = {rem_s[j][k], low_s[j][k][QuotW-1-j]};
        ge[k]    = (cur[k] >= RemW'(div_s[j]));
        rem_n[k] = ge[k] ? RootW'(cur[k] - RemW'(div_s[j])) : RootW'(cur[k]);
        q_n[k]   = {q_s[j][k][QuotW-2:0], ge[k]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[j+1] <= 1'b0;
      end else if (adv_i) begin
        vld_s[j+1] <= vld_s[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        div_s[j+1]   <= div_s[j];
        rem_s[j+1]   <= rem_n;
        low_s[j+1]   <= low_s[j];
        q_s[j+1]     <= q_n;
        flags_s[j+1] <= flags_s[j];
      end
    end
  end

  assign valid_o = vld_s[QuotW];
  assign q_o     = q_s[QuotW];
  assign flags_o = flags_s[QuotW];

  // A unit vector component never exceeds 1.0
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !flags_o.degen |->
      q_o[0] <= QuotOne && q_o[1] <= QuotOne && q_o[2] <= QuotOne)
    else $error("quotient above one");

endmodule

FILE: sv/pinhole_ray_direction_top.sv
// Pinhole camera primary ray direction: normalize(C + x*H + y*V) in Q1.15.
// Depends on prd_pkg, prd_isqrt and prd_div.
//
//   channel  | dir | handshake              | payload
//   request  | in  | in_valid_i / in_stall_o | in_data_i  (screen_x, screen_y)
//   result   | out | out_valid_o / out_stall_i | out_data_o (dir_x, dir_y, dir_z, degenerate)
//   config   | in  | APB psel/penable/pwrite | paddr 8*i, pwdata 63 bits used
//
// One request is taken every cycle while in_stall_o is low; each result passes the front stages,
// the 31-step square root, the 16-step divider and the output register, one bit per stage.
// Reset clears the valid bits (output and skid too) and the three camera registers.
// A stalled result sits in the output register; one more result lands in the skid
// register, and while that is full the whole pipeline holds and in_stall_o is high.
module pinhole_ray_direction_top import prd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  prd_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output prd_out_t         out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // ---------------------------------------------------------------- config
  logic [RegW-1:0] corner_q, hspan_q, vspan_q;
  prd_reg_e        reg_sel;
  logic            cfg_we;

  assign pready  = 1'b1;
  assign reg_sel = prd_reg_e'(paddr[AddrW-1:3]);
  assign cfg_we  = psel && penable && pwrite && pready;

  // Write the addressed register, drop writes past the map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
      hspan_q  <= '0;
      vspan_q  <= '0;
    end else if (cfg_we) begin
      case (reg_sel)
        RegCorner: corner_q <= pwdata[RegW-1:0];
        RegHspan:  hspan_q  <= pwdata[RegW-1:0];
        RegVspan:  vspan_q  <= pwdata[RegW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_sel)
      RegCorner: prdata = DataW'(corner_q);
      RegHspan:  prdata = DataW'(hspan_q);
      RegVspan:  prdata = DataW'(vspan_q);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  logic     adv;
  logic     out_valid_q, skid_valid_q;
  prd_out_t out_data_q, skid_data_q;
  logic     pop;

  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign pop        = out_valid_q && !out_stall_i;

  // ---------------------------------------------------------------- stage 1: products
  logic                    s1_vld_q;
  logic signed [CompW-1:0] s1_c_q  [NumComp];
  logic signed [ProdW-1:0] s1_px_q [NumComp];
  logic signed [ProdW-1:0] s1_py_q [NumComp];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumComp; k++) begin
        s1_c_q[k]  <= prd_comp(corner_q, k);
        s1_px_q[k] <= $signed({1'b0, in_data_i.screen_x}) * prd_comp(hspan_q, k);
        s1_py_q[k] <= $signed({1'b0, in_data_i.screen_y}) * prd_comp(vspan_q, k);
      end
    end
  end

  // ---------------------------------------------------------------- stage 2: sum
  logic                   s2_vld_q;
  logic signed [SumW-1:0] s2_d_q [NumComp];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumComp; k++) begin
        s2_d_q[k] <= (SumW'(s1_c_q[k]) <<< 16) + SumW'(s1_px_q[k]) + SumW'(s1_py_q[k]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: magnitude
  logic                s3_vld_q;
  logic [MagW-1:0]     s3_mag_q [NumComp];
  logic [NumComp-1:0]  s3_neg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumComp; k++) begin
        s3_neg_q[k] <= s2_d_q[k][SumW-1];
        s3_mag_q[k] <= s2_d_q[k][SumW-1] ? MagW'(-s2_d_q[k]) : MagW'(s2_d_q[k]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 4: largest magnitude
  logic               s4_vld_q;
  logic [MagW-1:0]    s4_mag_q [NumComp];
  logic [NumComp-1:0] s4_neg_q;
  logic [MagW-1:0]    s4_max_q;
  logic [MagW-1:0]    max01, max_d;

  always_comb begin
    max01 = (s3_mag_q[0] > s3_mag_q[1]) ? s3_mag_q[0] : s3_mag_q[1];
    max_d = (max01 > s3_mag_q[2]) ? max01 : s3_mag_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_mag_q <= s3_mag_q;
      s4_neg_q <= s3_neg_q;
      s4_max_q <= max_d;
    end
  end

  // ---------------------------------------------------------------- stage 5: shift amount
  logic               s5_vld_q;
  logic [MagW-1:0]    s5_mag_q [NumComp];
  logic [NumComp-1:0] s5_neg_q;
  logic               s5_degen_q;
  logic               s5_right_q;
  logic [PosW-1:0]    s5_amt_q;
  logic [PosW-1:0]    lead;

  // Find the leading one of the largest magnitude
  always_comb begin
    lead = '0;
    for (int i = 0; i < MagW; i++) begin
      if (s4_max_q[i]) lead = PosW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_mag_q   <= s4_mag_q;
      s5_neg_q   <= s4_neg_q;
      s5_degen_q <= (s4_max_q == '0);
      s5_right_q <= (lead >= PosW'(NormMsb));
      s5_amt_q   <= (lead >= PosW'(NormMsb)) ? lead - PosW'(NormMsb) : PosW'(NormMsb) - lead;
    end
  end

  // ---------------------------------------------------------------- stage 6: normalize
  logic               s6_vld_q;
  logic [NormW-1:0]   s6_e_q [NumComp];
  prd_flags_t         s6_flags_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumComp; k++) begin
        s6_e_q[k] <= s5_right_q ? NormW'(s5_mag_q[k] >> s5_amt_q)
                                : NormW'(s5_mag_q[k] << s5_amt_q);
      end
      s6_flags_q.neg   <= s5_neg_q;
      s6_flags_q.degen <= s5_degen_q;
    end
  end

  // ---------------------------------------------------------------- stage 7: squares
  logic               s7_vld_q;
  logic [SqW-1:0]     s7_sq_q [NumComp];
  prd_side_t          s7_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumComp; k++) begin
        s7_sq_q[k]     <= s6_e_q[k] * s6_e_q[k];
        s7_side_q.e[k] <= s6_e_q[k];
      end
      s7_side_q.flags <= s6_flags_q;
    end
  end

  // ---------------------------------------------------------------- stage 8: sum of squares
  logic               s8_vld_q;
  logic [RadW-1:0]    s8_rad_q;
  prd_side_t          s8_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_rad_q  <= RadW'(s7_sq_q[0]) + RadW'(s7_sq_q[1]) + RadW'(s7_sq_q[2]);
      s8_side_q <= s7_side_q;
    end
  end

  // Advance the valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
      s8_vld_q <= s7_vld_q;
    end
  end

  // ---------------------------------------------------------------- length and division
  logic                          sq_valid;
  logic [RootW-1:0]              sq_root;
  prd_side_t                     sq_side;
  logic                          dv_valid;
  logic [NumComp-1:0][QuotW-1:0] dv_q;
  prd_flags_t                    dv_flags;

  prd_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (s8_vld_q),
    .radicand_i (s8_rad_q),
    .side_i     (s8_side_q),
    .valid_o    (sq_valid),
    .root_o     (sq_root),
    .side_o     (sq_side)
  );

  prd_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (sq_valid),
    .divisor_i (sq_root),
    .side_i    (sq_side),
    .valid_o   (dv_valid),
    .q_o       (dv_q),
    .flags_o   (dv_flags)
  );

  // ---------------------------------------------------------------- sign and saturate
  logic [DirW-1:0] fmt [NumComp];
  prd_out_t        res;

  always_comb begin
    for (int k = 0; k < NumComp; k++) begin
      if (dv_flags.degen) begin
        fmt[k] = '0;
      end else if (dv_flags.neg[k]) begin
        fmt[k] = ~dv_q[k] + DirW'(1);
      end else begin
        fmt[k] = (dv_q[k] > DirMax) ? DirMax : dv_q[k];
      end
    end
    res.dir_x      = $signed(fmt[0]);
    res.dir_y      = $signed(fmt[1]);
    res.dir_z      = $signed(fmt[2]);
    res.degenerate = dv_flags.degen;
  end

  // ---------------------------------------------------------------- output and skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // Pipeline holds; refill the output from the skid once taken
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (dv_valid) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_data_q <= skid_data_q;
    end else if (dv_valid) begin
      if (!out_valid_q || pop) begin
        out_data_q <= res;
      end else begin
        skid_data_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------- checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_stall_i |=> skid_valid_q && $stable(skid_data_q))
    else $error("skid result lost under stall");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.degenerate |->
      out_data_q.dir_x == '0 && out_data_q.dir_y == '0 && out_data_q.dir_z == '0)
    else $error("zero vector with nonzero direction");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for pinhole_ray_direction_top: random and directed screen requests
// against a bit-exact direction predictor. Depends on prd_pkg and the RTL under sv/.
module testbench;
  import prd_pkg::*;

  localparam int unsigned CoordOne = 65536;   // 1.0 in Q1.16
  localparam int unsigned CoordMax = 131071;  // all coordinate bits set
  localparam int          CompMax  = 1048575;
  localparam int          CompMin  = -1048576;
  localparam longint unsigned NormHigh = 64'd1 << NormW;
  localparam longint unsigned NormLow  = 64'd1 << NormMsb;
  localparam logic [1:0] RegUnused = 2'd3;    // no register behind this index
  localparam int unsigned TailCycles = 80;    // pipeline is 57 deep

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  prd_in_t          in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  prd_out_t         out_data_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Shadow copy of the camera registers, indexed by register code
  logic [RegW-1:0] cam_regs [NumComp];

  prd_in_t     screen_q[$];
  prd_out_t    expected_dirs_q[$];
  prd_out_t    dir_want;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_next;
  int unsigned error_cnt = 0;
  bit          req_gaps_on = 1'b1;
  bit          res_stalls_on = 1'b1;

  pinhole_ray_direction_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Unit direction of C + x*H + y*V in Q1.15, flagged when the vector is zero
  function automatic prd_out_t ray_direction(prd_in_t req);
    logic signed [CompW-1:0] cc, hc, vc;
    longint c, h, v, x, y;
    longint d [NumComp];
    longint unsigned mag [NumComp];
    longint unsigned top, sumsq, len, trial, q;
    logic [DirW-1:0] dir [NumComp];
    prd_out_t res;
    x = req.screen_x;
    y = req.screen_y;
    top = 0;
    for (int k = 0; k < NumComp; k++) begin
      cc = cam_regs[RegCorner][k*CompW +: CompW];
      hc = cam_regs[RegHspan][k*CompW +: CompW];
      vc = cam_regs[RegVspan][k*CompW +: CompW];
      c = cc;
      h = hc;
      v = vc;
      d[k] = c * 65536 + x * h + y * v;
      mag[k] = (d[k] < 0) ? -d[k] : d[k];
      if (mag[k] > top) top = mag[k];
    end
    res = '0;
    if (top == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    // Scale all magnitudes together until the largest lies in [2^29, 2^30)
    while (top >= NormHigh) begin
      top = top >> 1;
      for (int k = 0; k < NumComp; k++) mag[k] = mag[k] >> 1;
    end
    while (top < NormLow) begin
      top = top << 1;
      for (int k = 0; k < NumComp; k++) mag[k] = mag[k] << 1;
    end
    sumsq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    // Build the floor square root one bit at a time
    len = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = len | (64'd1 << b);
      if (trial * trial <= sumsq) len = trial;
    end
    for (int k = 0; k < NumComp; k++) begin
      q = ((mag[k] << 15) + (len >> 1)) / len;
      if (d[k] < 0) begin
        q = -q;
        dir[k] = q[DirW-1:0];
      end else begin
        dir[k] = (q > DirMax) ? DirMax : q[DirW-1:0];
      end
    end
    res.dir_x = dir[0];
    res.dir_y = dir[1];
    res.dir_z = dir[2];
    return res;
  endfunction

  function automatic logic [RegW-1:0] pack3(int cx, int cy, int cz);
    return {cz[CompW-1:0], cy[CompW-1:0], cx[CompW-1:0]};
  endfunction

  // Mostly in [0, 1.0], sometimes the exact ends, sometimes past 1.0
  function automatic int unsigned draw_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom_range(0, CoordMax);
    if (pick == 1) return ($urandom_range(0, 1) != 0) ? CoordOne : 0;
    return $urandom_range(0, CoordOne);
  endfunction

  task automatic queue_ray(int unsigned x, int unsigned y);
    prd_in_t r;
    r.screen_x = x[CoordW-1:0];
    r.screen_y = y[CoordW-1:0];
    screen_q.push_back(r);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx <= RegVspan) cam_regs[idx] = value[RegW-1:0];
  endtask

  task automatic read_reg(logic [1:0] idx, output logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Read every register back and compare with the shadow copy
  task automatic check_regs();
    logic [DataW-1:0] rd;
    for (int i = RegCorner; i <= RegVspan; i++) begin
      read_reg(i[1:0], rd);
      if (rd[RegW-1:0] !== cam_regs[i]) begin
        $display("%0t: register %0d expected %h, got %h", $time, i, cam_regs[i],
                 rd[RegW-1:0]);
        error_cnt++;
      end
    end
  endtask

  task automatic load_camera(logic [RegW-1:0] c, logic [RegW-1:0] h, logic [RegW-1:0] v);
    write_reg(RegCorner, {1'b0, c});
    write_reg(RegHspan, {1'b0, h});
    write_reg(RegVspan, {1'b0, v});
    check_regs();
  endtask

  // Hold until every request is sent and every direction has come back;
  // step past the last pop so the final request shows as valid
  task automatic settle();
    while (screen_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    while (in_valid_i || expected_dirs_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_cnt++;
    end
  endtask

  // Request driver: launch queued requests, hold while stalled, idle at random between them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_dirs_q.push_back(ray_direction(in_data_i));
      if (in_valid_i && in_stall_o) begin
        // hold the stalled request
      end else if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (screen_q.size() != 0) begin
        in_data_i  <= screen_q.pop_front();
        in_valid_i <= 1'b1;
        gap_left   <= req_gaps_on ? $urandom_range(0, 19) : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor: check each accepted direction, stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_next = stall_left;
      if (out_valid_o && !out_stall_i) begin
        if (expected_dirs_q.size() == 0) begin
          $display("%0t: no direction expected, got %0d %0d %0d degenerate %0b", $time,
                   $signed(out_data_o.dir_x), $signed(out_data_o.dir_y),
                   $signed(out_data_o.dir_z), out_data_o.degenerate);
          error_cnt++;
        end else begin
          dir_want = expected_dirs_q.pop_front();
          compare_field("dir_x", $signed(dir_want.dir_x), $signed(out_data_o.dir_x));
          compare_field("dir_y", $signed(dir_want.dir_y), $signed(out_data_o.dir_y));
          compare_field("dir_z", $signed(dir_want.dir_z), $signed(out_data_o.dir_z));
          compare_field("degenerate", dir_want.degenerate, out_data_o.degenerate);
        end
        stall_next = res_stalls_on ? $urandom_range(0, 19) : 0;
      end else if (stall_next != 0) begin
        stall_next = stall_next - 1;
      end
      stall_left  <= stall_next;
      out_stall_i <= (stall_next != 0);
    end
  end

  // Stimulus
  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    for (int i = 0; i < NumComp; i++) cam_regs[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers still at reset: every direction is the zero vector
    queue_ray(0, 0);
    queue_ray(CoordOne, CoordOne);
    queue_ray(CoordMax, CoordMax);
    settle();

    // Typical camera, corners and centre of the screen, coordinates past 1.0
    load_camera(pack3(-2048, -1024, -1024), pack3(4096, 0, 0), pack3(0, 2048, 0));
    queue_ray(0, 0);
    queue_ray(CoordOne, 0);
    queue_ray(0, CoordOne);
    queue_ray(CoordOne, CoordOne);
    queue_ray(CoordOne / 2, CoordOne / 2);
    queue_ray(CoordMax, CoordMax);
    queue_ray(1, 1);
    queue_ray(CoordMax, 0);
    queue_ray(0, CoordMax);
    queue_ray(CoordOne - 1, CoordOne - 1);
    settle();

    // Direction along x only: zero at mid screen, +1.0 saturates, -1.0 comes out.
    // Also write the top data bit and the unused index; both must be dropped.
    write_reg(RegCorner, {1'b1, pack3(-2048, 0, 0)});
    write_reg(RegHspan, {1'b1, pack3(4096, 0, 0)});
    write_reg(RegVspan, '0);
    write_reg(RegUnused, '1);
    check_regs();
    queue_ray(CoordOne / 2, 0);
    queue_ray(CoordOne / 2, CoordMax);
    queue_ray(0, 5);
    queue_ray(CoordOne, CoordOne);
    queue_ray(CoordOne / 2 - 1, 0);
    queue_ray(CoordOne / 2 + 1, 0);
    queue_ray(CoordMax, CoordMax);
    settle();

    // Random phases over several camera settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_camera(pack3(-2048 + int'($urandom_range(0, 400)) - 200,
                             -1024 + int'($urandom_range(0, 400)) - 200,
                             -1024 + int'($urandom_range(0, 400)) - 200),
                       pack3(4096, int'($urandom_range(0, 64)) - 32, 0),
                       pack3(0, 2048, int'($urandom_range(0, 64)) - 32));
        1: load_camera(RegW'({$urandom, $urandom}), RegW'({$urandom, $urandom}),
                       RegW'({$urandom, $urandom}));
        2: load_camera(pack3(CompMax, CompMax, CompMax), pack3(CompMax, CompMax, CompMax),
                       pack3(CompMax, CompMax, CompMax));
        3: load_camera(pack3(CompMin, CompMin, CompMin), pack3(CompMin, CompMin, CompMin),
                       pack3(CompMin, CompMin, CompMin));
        4: load_camera(RegW'({$urandom, $urandom}), RegW'({$urandom, $urandom}),
                       RegW'({$urandom, $urandom}));
        default: load_camera(pack3(CompMax, CompMin, CompMax),
                             pack3(CompMin, CompMax, CompMin),
                             RegW'({$urandom, $urandom}));
      endcase
      req_gaps_on   = (ph != 1) && (ph != 2);
      res_stalls_on = (ph != 1) && (ph != 3);
      for (int n = 0; n < 92; n++) queue_ray(draw_coord(), draw_coord());
      settle();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (error_cnt == 0 && expected_dirs_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
sv/prd_pkg.sv
sv/prd_isqrt.sv
sv/prd_div.sv
sv/pinhole_ray_direction_top.sv
sim/testbench.sv
